FILE: rtl/hcs_pkg.sv
package hcs_pkg;

    localparam int LEVELS  = 256;
    localparam int PIX_W   = 8;
    localparam int ADDR_W  = $clog2(LEVELS);
    localparam int CNT_W   = 21;
    localparam int OP_W    = 2;
    localparam int SCAN_W  = ADDR_W + 1;
    localparam int NUM_W   = 2 * PIX_W;
    localparam int QSTEP_W = $clog2(PIX_W);

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // peak / 10 as a multiply by ceil(2^24 / 10); exact for every 21-bit peak
    localparam int               THR_SHIFT = 24;
    localparam logic [CNT_W-1:0] THR_RECIP = CNT_W'(((1 << THR_SHIFT) + 9) / 10);
    localparam int               PROD_W    = 2 * CNT_W;

    localparam logic [OP_W-1:0] OP_COUNT   = 2'd0;
    localparam logic [OP_W-1:0] OP_STRETCH = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    localparam logic [PIX_W-1:0] PIX_TOP = PIX_W'(LEVELS - 1);

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [PIX_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] raddr;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CNT_W-1:0]  wdata;
    } ram_req_t;

endpackage

FILE: rtl/hcs_bin_ram.sv
module hcs_bin_ram (
    input  logic                                clk,
    input  hcs_pkg::ram_req_t                   req,
    output logic [hcs_pkg::CNT_W-1:0]           rdata
);

    logic [hcs_pkg::CNT_W-1:0] mem [hcs_pkg::LEVELS];
    logic [hcs_pkg::CNT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/hcs_divider.sv
module hcs_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  hcs_pkg::div_req_t req,
    output hcs_pkg::div_rsp_t rsp
);

    logic                              busy_reg;
    logic [hcs_pkg::QSTEP_W-1:0]       step_reg;
    logic [hcs_pkg::PIX_W-1:0]         rem_reg;
    logic [hcs_pkg::PIX_W-1:0]         nlo_reg;
    logic [hcs_pkg::PIX_W-1:0]         den_reg;
    logic [hcs_pkg::PIX_W-1:0]         quot_reg;
    logic                              done_reg;
    logic [hcs_pkg::PIX_W:0]           trial;
    logic                              fits;
    logic [hcs_pkg::PIX_W:0]           diff;

    assign trial = {rem_reg, nlo_reg[hcs_pkg::PIX_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == hcs_pkg::QSTEP_W'(hcs_pkg::PIX_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // quotient stays below 256, so the upper numerator byte is already below den
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.num[hcs_pkg::NUM_W-1:hcs_pkg::PIX_W];
            nlo_reg <= req.num[hcs_pkg::PIX_W-1:0];
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[hcs_pkg::PIX_W-1:0] : trial[hcs_pkg::PIX_W-1:0];
            nlo_reg  <= {nlo_reg[hcs_pkg::PIX_W-2:0], 1'b0};
            quot_reg <= {quot_reg[hcs_pkg::PIX_W-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

FILE: rtl/histogram_contrast_stretch_top.sv
// Gray contrast stretch over a 256-bin histogram held in one synchronous RAM.
// Count transactions stream at one per cycle while in_ready is high (read,
// increment, write back, with forwarding between neighbors that hit the same
// bin); bins saturate at 2^21-1. A count marked last adds a scan of the whole
// RAM, one bin per read cycle; its result carries the new low and high bins.
// A stretch transaction skips the divider when the pixel is clamped or the range
// is flat; else the bit-serial divider gives the result, one quotient bit a cycle.
// A clear transaction zeroes the RAM bin by bin through its single write port;
// the same sweep runs after reset, during which in_ready stays low.
module histogram_contrast_stretch_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [hcs_pkg::OP_W-1:0]          operation,
    input  logic [hcs_pkg::PIX_W-1:0]         pixel,
    input  logic                              last,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [hcs_pkg::PIX_W-1:0]         stretched_pixel,
    output logic [hcs_pkg::PIX_W-1:0]         low_bin,
    output logic [hcs_pkg::PIX_W-1:0]         high_bin
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DIV    = 5'b00010,
        ST_SEARCH = 5'b00100,
        ST_CLEAR  = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [hcs_pkg::SCAN_W-1:0]      cnt_reg, cnt_next;

    logic                            s1_valid_reg;
    logic                            s1_last_reg;
    logic [hcs_pkg::ADDR_W-1:0]      s1_pix_reg;
    logic                            fwd_hit_reg;
    logic [hcs_pkg::CNT_W-1:0]       fwd_val_reg;

    logic [hcs_pkg::CNT_W-1:0]       peak_reg;
    logic [hcs_pkg::CNT_W-1:0]       thr_reg;
    logic [hcs_pkg::PIX_W-1:0]       range_low_reg, range_low_next;
    logic [hcs_pkg::PIX_W-1:0]       range_high_reg, range_high_next;
    logic [hcs_pkg::PIX_W-1:0]       scan_lo_reg, scan_lo_next;
    logic [hcs_pkg::PIX_W-1:0]       scan_hi_reg, scan_hi_next;
    logic                            found_reg, found_next;
    logic [hcs_pkg::PIX_W-1:0]       res_pix_reg, res_pix_next;

    logic                            out_valid_reg;
    logic [hcs_pkg::PIX_W-1:0]       out_pix_reg;
    logic [hcs_pkg::PIX_W-1:0]       out_low_reg;
    logic [hcs_pkg::PIX_W-1:0]       out_high_reg;

    logic                            in_fire;
    logic                            cnt_fire;
    logic [hcs_pkg::CNT_W-1:0]       rdata;
    logic [hcs_pkg::CNT_W-1:0]       cur_count;
    logic [hcs_pkg::CNT_W-1:0]       new_count;
    logic [hcs_pkg::PROD_W-1:0]      thr_prod;
    logic [hcs_pkg::SCAN_W-1:0]      scan_addr;
    logic                            scan_hit;
    logic [hcs_pkg::PIX_W-1:0]       diff_pix;
    logic                            px_below;
    logic                            px_above;
    logic                            range_flat;
    logic                            emit_load;
    hcs_pkg::ram_req_t               ram_req;
    hcs_pkg::div_req_t               div_req;
    hcs_pkg::div_rsp_t               div_rsp;

    assign in_ready = (state_reg == ST_IDLE) && !(s1_valid_reg && s1_last_reg);
    assign in_fire  = in_valid && in_ready;
    assign cnt_fire = in_fire && (operation == hcs_pkg::OP_COUNT);

    // count stage: forward the previous write when it targets the same bin
    assign cur_count = fwd_hit_reg ? fwd_val_reg : rdata;
    assign new_count = (cur_count == hcs_pkg::COUNT_MAX) ? cur_count : cur_count + 1'b1;

    assign thr_prod  = {{hcs_pkg::CNT_W{1'b0}}, peak_reg} *
                       {{hcs_pkg::CNT_W{1'b0}}, hcs_pkg::THR_RECIP};
    assign scan_addr = cnt_reg - 1'b1;
    assign scan_hit  = rdata >= thr_reg;

    assign px_below   = pixel < range_low_reg;
    assign px_above   = pixel > range_high_reg;
    assign range_flat = range_high_reg == range_low_reg;
    assign diff_pix   = pixel - range_low_reg;

    assign div_req.start = in_fire && (operation == hcs_pkg::OP_STRETCH) &&
                           !px_below && !px_above && !range_flat;
    assign div_req.num   = {diff_pix, {hcs_pkg::PIX_W{1'b0}}} -
                           {{hcs_pkg::PIX_W{1'b0}}, diff_pix};
    assign div_req.den   = range_high_reg - range_low_reg;

    always_comb
    begin
        ram_req.re    = 1'b0;
        ram_req.raddr = pixel;
        ram_req.we    = 1'b0;
        ram_req.waddr = s1_pix_reg;
        ram_req.wdata = new_count;
        if (cnt_fire)
        begin
            ram_req.re = 1'b1;
        end
        else if ((state_reg == ST_SEARCH) && !cnt_reg[hcs_pkg::ADDR_W])
        begin
            ram_req.re    = 1'b1;
            ram_req.raddr = cnt_reg[hcs_pkg::ADDR_W-1:0];
        end
        // a pending count write goes first; the sweep holds for it
        if (s1_valid_reg)
        begin
            ram_req.we = 1'b1;
        end
        else if (state_reg == ST_CLEAR)
        begin
            ram_req.we    = 1'b1;
            ram_req.waddr = cnt_reg[hcs_pkg::ADDR_W-1:0];
            ram_req.wdata = '0;
        end
    end

    hcs_bin_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (rdata)
    );

    hcs_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        range_low_next  = range_low_reg;
        range_high_next = range_high_reg;
        res_pix_next    = res_pix_reg;
        found_next      = found_reg;
        scan_lo_next    = scan_lo_reg;
        scan_hi_next    = scan_hi_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (s1_valid_reg && s1_last_reg)
                begin
                    state_next = ST_SEARCH;
                    found_next = 1'b0;
                end
                else if (in_fire)
                begin
                    if (operation == hcs_pkg::OP_STRETCH)
                    begin
                        res_pix_next = px_above ? hcs_pkg::PIX_TOP : '0;
                        state_next   = div_req.start ? ST_DIV : ST_EMIT;
                    end
                    else if (operation == hcs_pkg::OP_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_pix_next = div_rsp.quot;
                    state_next   = ST_EMIT;
                end
            end
            ST_SEARCH:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg != '0)
                begin
                    if (scan_hit)
                    begin
                        if (!found_reg)
                        begin
                            scan_lo_next = scan_addr[hcs_pkg::ADDR_W-1:0];
                        end
                        found_next   = 1'b1;
                        scan_hi_next = scan_addr[hcs_pkg::ADDR_W-1:0];
                    end
                    if (cnt_reg[hcs_pkg::ADDR_W])
                    begin
                        range_low_next  = found_next ? scan_lo_next : hcs_pkg::PIX_TOP;
                        range_high_next = found_next ? scan_hi_next : '0;
                        res_pix_next    = '0;
                        state_next      = ST_EMIT;
                    end
                end
            end
            ST_CLEAR:
            begin
                if (!s1_valid_reg)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg[hcs_pkg::ADDR_W-1:0] == hcs_pkg::PIX_TOP)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cnt_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            peak_reg       <= '0;
            range_low_reg  <= '0;
            range_high_reg <= hcs_pkg::PIX_TOP;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            s1_valid_reg   <= cnt_fire;
            fwd_hit_reg    <= cnt_fire && s1_valid_reg && (s1_pix_reg == pixel);
            range_low_reg  <= range_low_next;
            range_high_reg <= range_high_next;
            found_reg      <= found_next;
            if ((state_reg == ST_CLEAR) && (state_next == ST_IDLE))
            begin
                peak_reg <= '0;
            end
            else if (s1_valid_reg && (new_count > peak_reg))
            begin
                peak_reg <= new_count;
            end
            if (emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pix_reg   <= pixel;
        s1_last_reg  <= last;
        fwd_val_reg  <= new_count;
        res_pix_reg  <= res_pix_next;
        scan_lo_reg  <= scan_lo_next;
        scan_hi_reg  <= scan_hi_next;
        if ((state_reg == ST_SEARCH) && (cnt_reg == '0))
        begin
            thr_reg <= hcs_pkg::CNT_W'(thr_prod >> hcs_pkg::THR_SHIFT);
        end
        if (emit_load)
        begin
            out_pix_reg  <= res_pix_reg;
            out_low_reg  <= range_low_reg;
            out_high_reg <= range_high_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign stretched_pixel = out_pix_reg;
    assign low_bin         = out_low_reg;
    assign high_bin        = out_high_reg;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam logic [hcs_pkg::OP_W-1:0] OP_UNUSED   = 2'd3;
    localparam int                       HOLD_CYCLES = 1500;
    localparam int                       DRAIN_WAIT  = 300;
    localparam int                       CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [hcs_pkg::PIX_W-1:0] stretched;
        logic [hcs_pkg::PIX_W-1:0] low;
        logic [hcs_pkg::PIX_W-1:0] high;
    } stretch_out_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [hcs_pkg::OP_W-1:0]  operation;
    logic [hcs_pkg::PIX_W-1:0] pixel;
    logic                      last;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [hcs_pkg::PIX_W-1:0] stretched_pixel;
    logic [hcs_pkg::PIX_W-1:0] low_bin;
    logic [hcs_pkg::PIX_W-1:0] high_bin;

    // predictor state
    logic [hcs_pkg::CNT_W-1:0] hist_model [hcs_pkg::LEVELS];
    logic [hcs_pkg::CNT_W-1:0] peak_model;
    logic [hcs_pkg::PIX_W-1:0] lo_model;
    logic [hcs_pkg::PIX_W-1:0] hi_model;

    stretch_out_t awaited_outputs[$];

    int   send_idle_pct;
    int   recv_idle_pct;
    int   items_sent;
    int   mismatches = 0;
    int   cycles = 0;
    logic holding;
    event hold_start;

    histogram_contrast_stretch_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .pixel           (pixel),
        .last            (last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .stretched_pixel (stretched_pixel),
        .low_bin         (low_bin),
        .high_bin        (high_bin)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // long receiver hold-off, counted here so the sender keeps pushing
    initial
    begin
        holding = 1'b0;
        forever
        begin
            @(hold_start);
            @(posedge clk);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (holding)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        begin
            $display("mismatch on %s: got %0d, expected %0d", field, got, want);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        stretch_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_outputs.size() == 0)
                report_mismatch("unexpected transaction", 1, 0);
            else
            begin
                want = awaited_outputs.pop_front();
                if (stretched_pixel !== want.stretched)
                    report_mismatch("stretched_pixel", int'(stretched_pixel),
                                    int'(want.stretched));
                if (low_bin !== want.low)
                    report_mismatch("low_bin", int'(low_bin), int'(want.low));
                if (high_bin !== want.high)
                    report_mismatch("high_bin", int'(high_bin), int'(want.high));
            end
        end
    end

    task automatic predict_contrast(input logic [hcs_pkg::OP_W-1:0] op,
                                    input logic [hcs_pkg::PIX_W-1:0] px,
                                    input logic lst);
        stretch_out_t r;
        int           thr;
        int           lo;
        int           hi;
        begin
            if (op == hcs_pkg::OP_COUNT)
            begin
                if (int'(px) < hcs_pkg::LEVELS)
                begin
                    if (hist_model[px] != hcs_pkg::COUNT_MAX)
                        hist_model[px] = hist_model[px] + 1'b1;
                    if (hist_model[px] > peak_model)
                        peak_model = hist_model[px];
                end
                if (lst)
                begin
                    thr = int'(peak_model) / 10;
                    lo  = 0;
                    hi  = hcs_pkg::LEVELS - 1;
                    while (lo < hcs_pkg::LEVELS - 1 && int'(hist_model[lo]) < thr)
                        lo++;
                    while (hi > 0 && int'(hist_model[hi]) < thr)
                        hi--;
                    lo_model    = hcs_pkg::PIX_W'(lo);
                    hi_model    = hcs_pkg::PIX_W'(hi);
                    r.stretched = '0;
                    r.low       = lo_model;
                    r.high      = hi_model;
                    awaited_outputs.push_back(r);
                end
            end
            else if (op == hcs_pkg::OP_STRETCH)
            begin
                if (px < lo_model)
                    r.stretched = '0;
                else if (px > hi_model)
                    r.stretched = hcs_pkg::PIX_TOP;
                else if (hi_model <= lo_model)
                    r.stretched = '0;
                else
                    r.stretched = hcs_pkg::PIX_W'(
                        (int'(hcs_pkg::PIX_TOP) * (int'(px) - int'(lo_model)))
                        / (int'(hi_model) - int'(lo_model)));
                r.low  = lo_model;
                r.high = hi_model;
                awaited_outputs.push_back(r);
            end
            else if (op == hcs_pkg::OP_CLEAR)
            begin
                for (int i = 0; i < hcs_pkg::LEVELS; i++)
                    hist_model[i] = '0;
                peak_model = '0;
            end
        end
    endtask

    task automatic send_item(input logic [hcs_pkg::OP_W-1:0] op,
                             input logic [hcs_pkg::PIX_W-1:0] px,
                             input logic lst);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid  <= 1'b1;
            operation <= op;
            pixel     <= px;
            last      <= lst;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            predict_contrast(op, px, lst);
            if (op != OP_UNUSED)
                items_sent++;
        end
    endtask

    // full range after reset maps every pixel onto itself
    task automatic test_power_on;
        begin
            send_item(hcs_pkg::OP_STRETCH, 8'd0, 1'b0);
            send_item(hcs_pkg::OP_STRETCH, 8'd255, 1'b1);
            send_item(hcs_pkg::OP_STRETCH, 8'd77, 1'b0);
            send_item(OP_UNUSED, 8'd200, 1'b1);
        end
    endtask

    // a single count gives threshold zero, so every bin qualifies
    task automatic test_sparse_search;
        begin
            send_item(hcs_pkg::OP_CLEAR, 8'd0, 1'b1);
            send_item(hcs_pkg::OP_COUNT, 8'd7, 1'b1);
        end
    endtask

    task automatic test_flat_range;
        begin
            send_item(hcs_pkg::OP_CLEAR, 8'd255, 1'b0);
            for (int i = 0; i < 10; i++)
                send_item(hcs_pkg::OP_COUNT, 8'd100, i == 9);
            send_item(hcs_pkg::OP_STRETCH, 8'd100, 1'b0);
            send_item(hcs_pkg::OP_STRETCH, 8'd99, 1'b0);
            send_item(hcs_pkg::OP_STRETCH, 8'd101, 1'b0);
        end
    endtask

    // keep the bin of 100 at ten so single outliers just reach the threshold
    task automatic test_narrow_range;
        begin
            send_item(hcs_pkg::OP_COUNT, 8'd60, 1'b0);
            send_item(hcs_pkg::OP_COUNT, 8'd180, 1'b1);
            send_item(hcs_pkg::OP_STRETCH, 8'd59, 1'b0);
            send_item(hcs_pkg::OP_STRETCH, 8'd60, 1'b0);
            send_item(hcs_pkg::OP_STRETCH, 8'd120, 1'b0);
            send_item(hcs_pkg::OP_STRETCH, 8'd180, 1'b0);
            send_item(hcs_pkg::OP_STRETCH, 8'd181, 1'b0);
        end
    endtask

    task automatic test_backpressure;
        begin
            -> hold_start;
            for (int i = 0; i < 20; i++)
                send_item(hcs_pkg::OP_COUNT, 8'($urandom), i == 19);
            for (int i = 0; i < 40; i++)
                send_item(hcs_pkg::OP_STRETCH, 8'($urandom), 1'b0);
        end
    endtask

    task automatic test_random_images(input int target);
        int start_count;
        int n;
        int m;
        int center;
        int spread;
        int v;
        begin
            start_count = items_sent;
            while (items_sent - start_count < target)
            begin
                // skip the clear now and then to accumulate over images
                if ($urandom_range(7) != 0)
                    send_item(hcs_pkg::OP_CLEAR, 8'($urandom), 1'($urandom));
                n      = ($urandom_range(9) == 0) ? $urandom_range(100, 250)
                                                  : $urandom_range(1, 50);
                center = $urandom_range(255);
                spread = $urandom_range(40);
                for (int k = 0; k < n; k++)
                begin
                    case ($urandom_range(39))
                        0: send_item(OP_UNUSED, 8'($urandom), 1'($urandom));
                        1: send_item(hcs_pkg::OP_STRETCH, 8'($urandom), 1'($urandom));
                        2: send_item(hcs_pkg::OP_COUNT, 8'($urandom), 1'b1);
                        default: ;
                    endcase
                    if ($urandom_range(7) == 0)
                        v = $urandom_range(255);
                    else
                        v = center + $urandom_range(2 * spread) - spread;
                    v = (v < 0) ? 0 : (v > 255) ? 255 : v;
                    send_item(hcs_pkg::OP_COUNT, 8'(v), k == n - 1);
                end
                m = $urandom_range(1, 12);
                for (int k = 0; k < m; k++)
                begin
                    case ($urandom_range(3))
                        0: v = int'(lo_model) + $urandom_range(2) - 1;
                        1: v = int'(hi_model) + $urandom_range(2) - 1;
                        default: v = $urandom_range(255);
                    endcase
                    v = (v < 0) ? 0 : (v > 255) ? 255 : v;
                    send_item(hcs_pkg::OP_STRETCH, 8'(v), 1'($urandom));
                end
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        operation     = hcs_pkg::OP_COUNT;
        pixel         = '0;
        last          = 1'b0;
        items_sent    = 0;
        send_idle_pct = 38;
        recv_idle_pct = 65;
        for (int i = 0; i < hcs_pkg::LEVELS; i++)
            hist_model[i] = '0;
        peak_model = '0;
        lo_model   = '0;
        hi_model   = hcs_pkg::PIX_TOP;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on();
        test_sparse_search();
        test_flat_range();
        test_narrow_range();
        test_random_images(450);

        send_idle_pct = 65;
        recv_idle_pct = 38;
        test_random_images(450);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random_images(390);

        in_valid <= 1'b0;
        while (awaited_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (awaited_outputs.size() != 0)
            report_mismatch("outstanding transactions", 0, awaited_outputs.size());

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: histogram_contrast_stretch_top.f
rtl/hcs_pkg.sv
rtl/hcs_bin_ram.sv
rtl/hcs_divider.sv
rtl/histogram_contrast_stretch_top.sv
sim/tb_top.sv
